/* sv/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types for the sorted table search block: result codes, transaction kinds and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

    typedef enum logic [1:0] {
        ST_FOUND  = 2'd0,
        ST_MISS   = 2'd1,
        ST_LOADED = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef struct packed {
        logic    accept;      // capture key and set up pointers
        logic    ins_read;    // read entry below insert position
        logic    ins_shift;   // move read entry up one slot
        logic    ins_place;   // write key at insert position
        logic    srch_read;   // read entry at bisection midpoint
        logic    srch_step;   // narrow the search range
        logic    set_result;  // load output registers
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic full;         // table holds DEPTH entries
        logic pos_zero;     // insert position reached the bottom
        logic range_empty;  // no entries left in the search range
        logic gt;           // read entry greater than key
        logic eq;           // read entry equal to key
    } t_stat;

endpackage

/* sv/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted table of signed 32-bit values with insertion and bisection search.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load walks down from the top of the
// table, moving each larger entry up one slot; every move takes a read state
// and then a compare-and-write state, since the table read is registered. A
// search likewise takes a read state and a compare state per bisection probe,
// with up to log2(DEPTH)+1 probes. A load into a full table answers straight
// from idle without touching the table. Input ready is high only while no
// transaction is in flight or waiting on the output.
module sorted_table_binary_search #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_index,
    output logic [2:0]         o_probes
);
    import stbs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    stbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    stbs_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (i_value),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_status (o_status),
        .o_index  (o_index),
        .o_probes (o_probes)
    );

endmodule

/* sv/stbs_ctrl.sv */
// ----------------------------------------------------------------------------
// stbs_ctrl
// Sequencer for insertion and bisection search; drives datapath commands.
// ----------------------------------------------------------------------------
module stbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_kind,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  stbs_pkg::t_stat i_stat,
    output stbs_pkg::t_cmd  o_cmd
);
    import stbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = r_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_SEARCH) begin
                        n_state = S_SRCH_RD;
                    end else if (i_stat.full) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_DONE;
                        n_valid          = 1'b1;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.ins_place  = 1'b1;
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = ST_LOADED;
                    n_state          = S_DONE;
                    n_valid          = 1'b1;
                end else begin
                    o_cmd.ins_read = 1'b1;
                    n_state        = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.gt) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_place  = 1'b1;
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = ST_LOADED;
                    n_state          = S_DONE;
                    n_valid          = 1'b1;
                end
            end
            S_SRCH_RD: begin
                if (i_stat.range_empty) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = ST_MISS;
                    n_state          = S_DONE;
                    n_valid          = 1'b1;
                end else begin
                    o_cmd.srch_read = 1'b1;
                    n_state         = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.res_status = ST_FOUND;
                    n_state          = S_DONE;
                    n_valid          = 1'b1;
                end else begin
                    o_cmd.srch_step = 1'b1;
                    n_state         = S_SRCH_RD;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

/* sv/stbs_dpath.sv */
// ----------------------------------------------------------------------------
// stbs_dpath
// Table memory, entry count, insert and bisection pointers, result registers.
// ----------------------------------------------------------------------------
module stbs_dpath #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_value,
    input  stbs_pkg::t_cmd     i_cmd,
    output stbs_pkg::t_stat    o_stat,
    output logic [1:0]         o_status,
    output logic [3:0]         o_index,
    output logic [2:0]         o_probes
);
    import stbs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_key;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_pos;
    logic [CW-1:0]      r_low;
    logic [CW-1:0]      r_hi1;     // one past the top of the search range
    logic [AW-1:0]      r_mid;
    logic [CW-1:0]      r_probes;
    t_status            r_status;
    logic [3:0]         r_index;
    logic [2:0]         r_probes_out;

    logic [CW-1:0]      w_diff;
    logic [CW-1:0]      w_mid;
    logic [AW-1:0]      w_rd_addr;
    logic [AW+3:0]      w_index_ext;
    logic [CW+2:0]      w_probes_ext;

    assign w_diff    = r_hi1 - r_low - CW'(1);
    assign w_mid     = r_low + (w_diff >> 1);
    assign w_rd_addr = i_cmd.srch_read ? w_mid[AW-1:0] : (r_pos - AW'(1));

    assign o_stat.full        = (r_count == CW'(DEPTH));
    assign o_stat.pos_zero    = (r_pos == '0);
    assign o_stat.range_empty = (r_low >= r_hi1);
    assign o_stat.gt          = (r_rdata > r_key);
    assign o_stat.eq          = (r_rdata == r_key);

    assign w_index_ext  = {4'b0, r_mid};
    assign w_probes_ext = {3'b0, r_probes};

    // table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_read || i_cmd.srch_read) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.ins_shift) begin
            r_mem[r_pos] <= r_rdata;
        end else if (i_cmd.ins_place) begin
            r_mem[r_pos] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_place) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key    <= i_value;
            r_pos    <= r_count[AW-1:0];
            r_low    <= '0;
            r_hi1    <= r_count;
            r_probes <= '0;
        end
        if (i_cmd.ins_shift) begin
            r_pos <= r_pos - AW'(1);
        end
        if (i_cmd.srch_read) begin
            r_mid    <= w_mid[AW-1:0];
            r_probes <= r_probes + CW'(1);
        end
        if (i_cmd.srch_step) begin
            if (r_rdata < r_key) begin
                r_low <= CW'(r_mid) + CW'(1);
            end else begin
                r_hi1 <= CW'(r_mid);
            end
        end
        if (i_cmd.set_result) begin
            r_status     <= i_cmd.res_status;
            r_index      <= (i_cmd.res_status == ST_FOUND) ? w_index_ext[3:0] : 4'd0;
            r_probes_out <= (i_cmd.res_status == ST_FOUND || i_cmd.res_status == ST_MISS)
                            ? w_probes_ext[2:0] : 3'd0;
        end
    end

    assign o_status = r_status;
    assign o_index  = r_index;
    assign o_probes = r_probes_out;

endmodule
